// File: rtl/aip_pkg.sv
// Shared types and constants for the ASCII integer parser.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package aip_pkg;

    localparam int ACC_W      = 64;
    localparam int BASE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;

    localparam logic [BASE_W-1:0] BASE_BIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // One classified character as it sits in the queue
    typedef struct packed {
        logic [3:0] digit;
        logic       is_digit;
        logic       is_dec;
        logic       is_zero;
        logic       is_minus;
        logic       is_plus;
        logic       is_x;
        logic       is_b;
        logic       no_char;
        logic       last;
    } tok_t;

    typedef struct packed {
        logic [BASE_W-1:0] radix;
        logic              signed_mode;
        logic [1:0]        width_select;
    } cfg_t;

endpackage

// File: rtl/aip_ifs.sv
// Handshake interfaces of the ASCII integer parser: character input, result output
// and configuration write channel. Depends on aip_pkg.

interface aip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       no_char;
    logic       last;

    modport source (output valid, char_code, no_char, last, input ready);
    modport sink   (input valid, char_code, no_char, last, output ready);
endinterface

interface aip_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

interface aip_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aip_pkg::CFG_IDX_W-1:0]  index;
    logic [aip_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ascii_integer_parser_core.sv
// Top level of the ASCII integer parser: configuration registers, front end, token
// queue and parse engine. Depends on aip_pkg, aip_ifs, aip_front, aip_queue, aip_back.

// The parser takes one ASCII character per accepted word on chars and, on the word marked
// last, gives one word on results: the value (sign-extended to 64 bits, zero on error) and a
// status of ok, invalid or out of range. It sustains one character per clock cycle while a
// stalled results channel has not filled the queue: the per-character multiply-add of the
// 64-bit accumulator by the base, with exact overflow detection, is combinational in the
// parse engine. After its last character is accepted, a result passes the queue entry,
// then the finish snapshot, then the result register on its way to results. A two-entry
// queue sits between the character classifier and the engine,
// so chars.ready depends only on queue occupancy, never on results.ready. There is no
// clearing pass after reset. Configuration words on cfg are always accepted (ready is
// tied high); index 0 is the radix, 1 the signed mode, 2 the width select, and any other
// index is ignored. Write them only while no string is in flight.

module ascii_integer_parser_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    aip_char_if.sink      chars,
    aip_result_if.source  results,
    aip_cfg_if.sink       cfg
);

    // config registers
    logic [aip_pkg::BASE_W-1:0] radix_reg;
    logic                       signed_mode_reg;
    logic [1:0]                 width_select_reg;
    aip_pkg::cfg_t              cfg_cur;

    // front -> queue
    logic                       push_valid;
    logic                       push_ready;
    aip_pkg::tok_t              push_tok;

    // queue -> engine
    logic                       pop_valid;
    logic                       pop_ready;
    aip_pkg::tok_t              pop_tok;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= '0;
            signed_mode_reg  <= 1'b1;
            width_select_reg <= 2'd3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                aip_pkg::CFG_RADIX:  radix_reg        <= cfg.data[aip_pkg::BASE_W-1:0];
                aip_pkg::CFG_SIGNED: signed_mode_reg  <= cfg.data[0];
                aip_pkg::CFG_WIDTH:  width_select_reg <= cfg.data[1:0];
                default:             radix_reg        <= radix_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg_cur.radix        = radix_reg;
        cfg_cur.signed_mode  = signed_mode_reg;
        cfg_cur.width_select = width_select_reg;
    end

    aip_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (push_tok)
    );

    aip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (push_tok),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_tok    (pop_tok)
    );

    aip_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_cur),
        .tok_valid (pop_valid),
        .tok_ready (pop_ready),
        .tok       (pop_tok),
        .results   (results)
    );

endmodule

// File: rtl/aip_front.sv
// Front end: takes characters from the input channel and classifies them into tokens.
// Depends on aip_pkg and aip_ifs.

module aip_front (
    aip_char_if.sink       chars,
    output logic           push_valid,
    input  logic           push_ready,
    output aip_pkg::tok_t  push_tok
);

    logic [7:0] c;
    logic       lower_hex;
    logic       upper_hex;

    always_comb
    begin
        c         = chars.char_code;
        lower_hex = (c >= aip_pkg::CH_LA) && (c <= aip_pkg::CH_LF);
        upper_hex = (c >= aip_pkg::CH_UA) && (c <= aip_pkg::CH_UF);

        push_tok          = '0;
        push_tok.is_dec   = (c >= aip_pkg::CH_ZERO) && (c <= aip_pkg::CH_NINE);
        push_tok.is_digit = push_tok.is_dec || lower_hex || upper_hex;
        // letters a-f / A-F have low nibble 1..6
        push_tok.digit    = push_tok.is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
        push_tok.is_zero  = (c == aip_pkg::CH_ZERO);
        push_tok.is_minus = (c == aip_pkg::CH_MINUS);
        push_tok.is_plus  = (c == aip_pkg::CH_PLUS);
        push_tok.is_x     = (c == aip_pkg::CH_X);
        push_tok.is_b     = (c == aip_pkg::CH_B);
        push_tok.no_char  = chars.no_char;
        push_tok.last     = chars.last;
    end

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

// File: rtl/aip_queue.sv
// Short token queue between front end and parse engine.
// Depends on aip_pkg.

module aip_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  aip_pkg::tok_t  push_tok,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aip_pkg::tok_t  pop_tok
);

    aip_pkg::tok_t                 entries_reg [aip_pkg::Q_DEPTH];
    logic [aip_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [aip_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [aip_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    function automatic logic [aip_pkg::Q_PTR_W-1:0] bump(
        input logic [aip_pkg::Q_PTR_W-1:0] p
    );
        return (p == aip_pkg::Q_PTR_W'(aip_pkg::Q_DEPTH - 1)) ? '0
                                                              : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != aip_pkg::Q_CNT_W'(aip_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// File: rtl/aip_back.sv
// Parse engine: per-character state machine with multiply-add accumulator, then a
// finish stage (range check, sign) feeding the result register. Depends on aip_pkg, aip_ifs.

module aip_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  aip_pkg::cfg_t  cfg,
    input  logic           tok_valid,
    output logic           tok_ready,
    input  aip_pkg::tok_t  tok,
    aip_result_if.source   results
);

    localparam int AW = aip_pkg::ACC_W;
    localparam int BW = aip_pkg::BASE_W;

    // parse state
    aip_pkg::phase_t   phase_reg, phase_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [BW-1:0]     base_reg, base_next;
    logic              neg_reg, neg_next;
    aip_pkg::status_t  err_reg, err_next;

    // finish snapshot
    logic              fin_valid_reg;
    logic [AW-1:0]     fin_acc_reg;
    logic              fin_neg_reg;
    logic              fin_early_reg;
    aip_pkg::status_t  fin_err_reg;

    // result register
    logic              out_valid_reg;
    logic [AW-1:0]     out_value_reg, out_value_next;
    aip_pkg::status_t  out_status_reg, out_status_next;

    logic              out_load;
    logic              fin_adv;
    logic              tok_pop;
    logic              active;
    logic              auto_base;
    logic              do_add;
    logic [BW-1:0]     chk_base;
    logic [AW+BW-1:0]  prod;
    logic [AW+BW:0]    sum;
    logic              ovf;

    logic [6:0]        w_full;
    logic [6:0]        w_used;
    logic [6:0]        lim_bits;
    logic [AW-1:0]     lim;
    logic [AW-1:0]     lim_eff;

    assign out_load  = !out_valid_reg || results.ready;
    assign fin_adv   = fin_valid_reg && out_load;
    assign tok_ready = !fin_valid_reg || out_load;
    assign tok_pop   = tok_valid && tok_ready;
    assign active    = !tok.no_char && (err_reg == aip_pkg::ST_OK);
    assign auto_base = (cfg.radix == '0);

    // acc_reg is zero outside PH_DIGITS, so the multiplier always uses the stored base
    assign prod = (AW+BW)'(acc_reg) * (AW+BW)'(base_reg);
    assign sum  = (AW+BW+1)'(prod) + (AW+BW+1)'(tok.digit);
    assign ovf  = |sum[AW+BW:AW];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active)
        begin
            unique case (phase_reg)
                aip_pkg::PH_START:
                begin
                    if (tok.is_minus)
                    begin
                        if (cfg.signed_mode)
                        begin
                            phase_next = aip_pkg::PH_SIGNED;
                        end
                    end
                    else if (tok.is_plus)
                    begin
                        phase_next = aip_pkg::PH_SIGNED;
                    end
                    else if (tok.is_zero)
                    begin
                        phase_next = aip_pkg::PH_ZERO;
                    end
                    else if (!auto_base || tok.is_dec)
                    begin
                        phase_next = aip_pkg::PH_DIGITS;
                    end
                end
                aip_pkg::PH_SIGNED:
                begin
                    if (tok.is_zero)
                    begin
                        phase_next = aip_pkg::PH_ZERO;
                    end
                    else if (!auto_base || tok.is_dec)
                    begin
                        phase_next = aip_pkg::PH_DIGITS;
                    end
                end
                aip_pkg::PH_ZERO:   phase_next = aip_pkg::PH_DIGITS;
                aip_pkg::PH_DIGITS: phase_next = aip_pkg::PH_DIGITS;
            endcase
        end
    end

    // datapath for one character
    always_comb
    begin
        acc_next  = acc_reg;
        base_next = base_reg;
        neg_next  = neg_reg;
        err_next  = err_reg;
        do_add    = 1'b0;
        chk_base  = base_reg;
        if (active)
        begin
            unique case (phase_reg)
                aip_pkg::PH_START, aip_pkg::PH_SIGNED:
                begin
                    if ((phase_reg == aip_pkg::PH_START) && tok.is_minus)
                    begin
                        if (cfg.signed_mode)
                        begin
                            neg_next = 1'b1;
                        end
                        else
                        begin
                            err_next = aip_pkg::ST_INVALID;
                        end
                    end
                    else if ((phase_reg == aip_pkg::PH_START) && tok.is_plus)
                    begin
                        neg_next = neg_reg;
                    end
                    else if (!tok.is_zero)
                    begin
                        if (auto_base && !tok.is_dec)
                        begin
                            err_next = aip_pkg::ST_INVALID;
                        end
                        else
                        begin
                            base_next = auto_base ? aip_pkg::BASE_DEC : cfg.radix;
                            chk_base  = base_next;
                            do_add    = 1'b1;
                        end
                    end
                end
                aip_pkg::PH_ZERO:
                begin
                    if (tok.is_x)
                    begin
                        base_next = auto_base ? aip_pkg::BASE_HEX : cfg.radix;
                    end
                    else if (tok.is_b)
                    begin
                        base_next = auto_base ? aip_pkg::BASE_BIN : cfg.radix;
                    end
                    else
                    begin
                        base_next = auto_base ? aip_pkg::BASE_OCT : cfg.radix;
                        chk_base  = base_next;
                        do_add    = 1'b1;
                    end
                end
                aip_pkg::PH_DIGITS:
                begin
                    do_add = 1'b1;
                end
            endcase

            if (do_add)
            begin
                if (!tok.is_digit || (chk_base == '0) || (BW'(tok.digit) >= chk_base))
                begin
                    err_next = aip_pkg::ST_INVALID;
                end
                else if (ovf)
                begin
                    err_next = aip_pkg::ST_RANGE;
                end
                else
                begin
                    acc_next = sum[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aip_pkg::PH_START;
            acc_reg   <= '0;
            base_reg  <= '0;
            neg_reg   <= 1'b0;
            err_reg   <= aip_pkg::ST_OK;
        end
        else if (tok_pop)
        begin
            if (tok.last)
            begin
                phase_reg <= aip_pkg::PH_START;
                acc_reg   <= '0;
                base_reg  <= '0;
                neg_reg   <= 1'b0;
                err_reg   <= aip_pkg::ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
                err_reg   <= err_next;
            end
        end
    end

    // finish snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (tok_pop && tok.last)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_adv)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && tok.last)
        begin
            fin_acc_reg   <= acc_next;
            fin_neg_reg   <= neg_next;
            fin_early_reg <= (phase_next == aip_pkg::PH_START) ||
                             (phase_next == aip_pkg::PH_SIGNED);
            fin_err_reg   <= err_next;
        end
    end

    // range limit from the configured width
    always_comb
    begin
        w_full   = 7'd8 << cfg.width_select;
        w_used   = (w_full > 7'(VALUE_WIDTH)) ? 7'(VALUE_WIDTH) : w_full;
        lim_bits = cfg.signed_mode ? w_used - 7'd1 : w_used;
        lim      = (lim_bits >= 7'(AW)) ? {AW{1'b1}}
                                        : ((AW'(1) << lim_bits) - AW'(1));
        lim_eff  = lim + AW'(fin_neg_reg);
    end

    always_comb
    begin
        out_status_next = fin_err_reg;
        out_value_next  = '0;
        if ((out_status_next == aip_pkg::ST_OK) && fin_early_reg && auto_base)
        begin
            out_status_next = aip_pkg::ST_INVALID;
        end
        if ((out_status_next == aip_pkg::ST_OK) && fin_neg_reg && !cfg.signed_mode)
        begin
            out_status_next = aip_pkg::ST_INVALID;
        end
        if (out_status_next == aip_pkg::ST_OK)
        begin
            if (fin_acc_reg > lim_eff)
            begin
                out_status_next = aip_pkg::ST_RANGE;
            end
            else
            begin
                out_value_next = fin_neg_reg ? AW'(0) - fin_acc_reg : fin_acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_adv)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = out_value_reg;
    assign results.status = out_status_reg;

    // accumulator only holds digits once the digit phase is reached
    a_acc_zero_outside_digits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg != aip_pkg::PH_DIGITS) |-> (acc_reg == '0)
    ) else $error("accumulator nonzero outside digit phase");

    a_clear_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (tok_pop && tok.last) |=>
            ((phase_reg == aip_pkg::PH_START) && (acc_reg == '0) &&
             (err_reg == aip_pkg::ST_OK) && !neg_reg)
    ) else $error("parse state not cleared after last character");

    a_error_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((err_reg != aip_pkg::ST_OK) && !(tok_pop && tok.last)) |=>
            (err_reg == $past(err_reg))
    ) else $error("error code changed before end of string");

    a_snapshot_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !out_load) |=> (fin_valid_reg && $stable(fin_acc_reg))
    ) else $error("pending result lost while output stalled");

endmodule

// File: bench/tb.sv
// Self-checking bench for ascii_integer_parser_core: feeds character words, predicts each
// result in step with the accepted words and compares it with the result channel.
// Depends on aip_pkg, the aip_*_if interfaces and the parser RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    localparam int          VALUE_WIDTH      = 64;
    localparam int          NUM_PHASES       = 16;
    localparam int          ITEMS_PER_PHASE  = 106;
    localparam int          SETTLE_CYCLES    = 10;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT   = 4000;  // cycles with no word on any channel
    localparam int unsigned RADIX_PLAN [NUM_PHASES] =
        '{0, 10, 16, 0, 2, 8, 1, 17, 31, 0, 10, 16, 3, 0, 5, 0};

    // one character word as queued for the driver
    typedef struct {
        logic [7:0] code;
        logic       no_char;
        logic       last;
    } char_word_t;

    // one parse result as the predictor expects it
    typedef struct {
        logic [63:0] value;
        status_t     status;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    aip_char_if   char_ch ();
    aip_result_if res_ch ();
    aip_cfg_if    cfg_ch ();

    ascii_integer_parser_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus and scoreboard state
    // ------------------------------------------------------------------
    char_word_t    pending_chars[$];     // words waiting for the driver
    parse_result_t expected_results[$];  // predictions not yet matched
    logic [7:0]    line_buf[$];          // string under construction
    string         noise_pool = "0123456789abcdefABCDEFxXbB+- g";

    int unsigned items_queued   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int          fail_count     = 0;
    int          stuck_cycles   = 0;
    int          results_seen   = 0;
    logic        word_taken;             // a char word was accepted at the last rising edge
    logic        rx_hold = 1'b0;         // long back-pressure stretch in progress
    event        start_long_hold;

    // settings the generator aims at (mirror what was last written)
    logic [4:0]  cur_radix;
    logic        cur_signed;
    logic [1:0]  cur_width;

    // ------------------------------------------------------------------
    // Predictor: configuration copy and parse state
    // ------------------------------------------------------------------
    logic [4:0]  sh_radix;
    logic        sh_signed;
    logic [1:0]  sh_width;

    phase_t      pr_phase;
    logic [63:0] pr_total;
    logic        pr_neg;
    logic [4:0]  pr_base;
    status_t     pr_err;

    function automatic void restart_parse();
        pr_phase = PH_START;
        pr_total = '0;
        pr_neg   = 1'b0;
        pr_base  = '0;
        pr_err   = ST_OK;
    endfunction

    // 16 marks "not a hex digit"
    function automatic logic [4:0] digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
        return 5'd16;
    endfunction

    // exact 64-bit multiply-add; digit at or above the base is invalid
    function automatic void fold_digit(logic [7:0] c);
        logic [4:0]  d;
        logic [63:0] b;
        d = digit_value(c);
        b = 64'(pr_base);
        if (d > 5'd15 || b == 0 || 64'(d) >= b)
        begin
            pr_err = ST_INVALID;
            return;
        end
        if (pr_total > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / b)
        begin
            pr_err = ST_RANGE;
            return;
        end
        pr_total = pr_total * b + 64'(d);
    endfunction

    // first character after an optional sign
    function automatic void open_number(logic [7:0] c);
        if (c == CH_ZERO)
        begin
            pr_phase = PH_ZERO;
            return;
        end
        if (sh_radix == 0)
        begin
            // auto mode without prefix: must start with a decimal digit
            if (c < CH_ZERO || c > CH_NINE)
            begin
                pr_err = ST_INVALID;
                return;
            end
            pr_base = BASE_DEC;
        end
        else
            pr_base = sh_radix;
        pr_phase = PH_DIGITS;
        fold_digit(c);
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        case (pr_phase)
            PH_START:
            begin
                if (c == CH_MINUS)
                begin
                    if (sh_signed)
                    begin
                        pr_neg   = 1'b1;
                        pr_phase = PH_SIGNED;
                    end
                    else
                        pr_err = ST_INVALID;
                end
                else if (c == CH_PLUS)
                    pr_phase = PH_SIGNED;
                else
                    open_number(c);
            end
            PH_SIGNED:
                open_number(c);
            PH_ZERO:
            begin
                // prefix is stripped even when radix is forced
                pr_phase = PH_DIGITS;
                if (c == CH_X)
                    pr_base = (sh_radix != 0) ? sh_radix : BASE_HEX;
                else if (c == CH_B)
                    pr_base = (sh_radix != 0) ? sh_radix : BASE_BIN;
                else
                begin
                    pr_base = (sh_radix != 0) ? sh_radix : BASE_OCT;
                    fold_digit(c);
                end
            end
            default:
                fold_digit(c);
        endcase
    endfunction

    // end of string: range check with the width and signedness in force now
    function automatic void finish_string();
        logic [63:0] lim;
        logic [63:0] v;
        int unsigned w;
        status_t     st;
        st = pr_err;
        v  = '0;
        if (st == ST_OK && (pr_phase == PH_START || pr_phase == PH_SIGNED) && sh_radix == 0)
            st = ST_INVALID;
        if (st == ST_OK && pr_neg && !sh_signed)
            st = ST_INVALID;
        if (st == ST_OK)
        begin
            w = 32'd8 << sh_width;
            if (w > VALUE_WIDTH)
                w = VALUE_WIDTH;
            if (sh_signed)
            begin
                lim = (w >= 64) ? 64'h7FFF_FFFF_FFFF_FFFF : (64'd1 << (w - 1)) - 64'd1;
                if (pr_neg)
                    lim = lim + 64'd1;
            end
            else
                lim = (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << w) - 64'd1;
            if (pr_total > lim)
                st = ST_RANGE;
            else
                v = pr_neg ? 64'd0 - pr_total : pr_total;
        end
        expected_results.push_back('{v, st});
        restart_parse();
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(logic [7:0] code, logic no_char, logic last);
        pending_chars.push_back('{code, no_char, last});
        items_queued++;
    endfunction

    // line_buf -> words; stray empty words sprinkled in, optional empty closing word
    function automatic void queue_line(bit empty_tail);
        for (int i = 0; i < line_buf.size(); i++)
        begin
            if ($urandom_range(0, 99) < 4)
                push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            push_word(line_buf[i], 1'b0, (i == line_buf.size() - 1) && !empty_tail);
        end
        if (empty_tail || line_buf.size() == 0)
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endfunction

    function automatic void send_text(string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        queue_line(1'b0);
    endfunction

    function automatic logic [7:0] digit_char(int unsigned d);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    // well-formed number aimed at the current settings, magnitudes small, random or near the range edges
    function automatic void build_number();
        int unsigned base;
        int unsigned w;
        int unsigned pick;
        logic [63:0] mag;
        bit          too_big;
        logic [7:0]  rev[$];
        line_buf.delete();
        too_big = 1'b0;
        mag     = '0;
        pick = $urandom_range(0, 9);
        // minus is rarer when unsigned, where it can only give invalid
        if (pick < (cur_signed ? 3 : 1))
            line_buf.push_back(CH_MINUS);
        else if (pick < 5)
            line_buf.push_back(CH_PLUS);
        if (cur_radix == 0)
        begin
            pick = $urandom_range(0, 3);
            base = (pick == 1) ? 16 : (pick == 2) ? 2 : (pick == 3) ? 8 : 10;
        end
        else
        begin
            pick = $urandom_range(0, 5);
            pick = (pick < 3) ? 0 : pick - 2;
            base = cur_radix;
        end
        // 1: 0x, 2: 0b, 3: lone leading zero
        if (pick != 0)
            line_buf.push_back(CH_ZERO);
        if (pick == 1)
            line_buf.push_back(CH_X);
        else if (pick == 2)
            line_buf.push_back(CH_B);

        if (base < 2 || base > 16)
        begin
            // odd radix: radix 1 takes only zeros, 17..31 takes 0-f
            repeat ($urandom_range(1, 17))
                line_buf.push_back(digit_char((base < 2) ? 0 : $urandom_range(0, 15)));
        end
        else
        begin
            w = 32'd8 << cur_width;
            case ($urandom_range(0, 7))
                0, 1: mag = 64'($urandom_range(0, 300));
                2:    mag = (w == 64) ? 64'h7FFF_FFFF_FFFF_FFFF : (64'd1 << (w - 1)) - 64'd1;
                3:    mag = (w == 64) ? 64'h8000_0000_0000_0000 : 64'd1 << (w - 1);
                4:    mag = (w == 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << w) - 64'd1;
                5:
                begin
                    if (w == 64)
                    begin
                        too_big = 1'b1;
                        mag     = '1;
                    end
                    else
                        mag = 64'd1 << w;
                end
                6:    mag = {$urandom, $urandom} >> $urandom_range(0, 63);
                default:
                begin
                    too_big = 1'b1;
                    mag     = '1;
                end
            endcase
            do
            begin
                rev.push_front(digit_char(int'(mag % base)));
                mag = mag / base;
            end
            while (mag != 0);
            line_buf = {line_buf, rev};
            // one more digit past 2^64-1 overflows for every base
            if (too_big)
                line_buf.push_back(CH_ZERO);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic write_config(logic [4:0] radix, logic sgn, logic [1:0] wsel);
        write_reg(CFG_RADIX, radix);
        write_reg(CFG_SIGNED, CFG_DATA_W'(sgn));
        write_reg(CFG_WIDTH, CFG_DATA_W'(wsel));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_radix  = radix;
        cur_signed = sgn;
        cur_width  = wsel;
    endtask

    // all words sent, all results back, then a margin for anything still in the pipe
    task automatic wait_drained();
        while (pending_chars.size() != 0 || char_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Char driver: changes on the falling edge, holds a word until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_chars
        char_word_t nxt;
        if (!rst_n)
            char_ch.valid <= 1'b0;
        else if (!char_ch.valid || word_taken)
        begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                nxt = pending_chars.pop_front();
                char_ch.valid     <= 1'b1;
                char_ch.char_code <= nxt.code;
                char_ch.no_char   <= nxt.no_char;
                char_ch.last      <= nxt.last;
            end
            else
                char_ch.valid <= 1'b0;
        end
    end

    // Result ready: random stalls, plus the long hold when asked for
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Long back-pressure stretch, timed here so the sender keeps offering words
    always
    begin
        @(start_long_hold);
        rx_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: config shadow, prediction on accepted words, result check
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : observe
        parse_result_t want;
        if (!rst_n)
        begin
            sh_radix  = 5'd0;
            sh_signed = 1'b1;
            sh_width  = 2'd3;
            restart_parse();
            word_taken   <= 1'b0;
            stuck_cycles = 0;
        end
        else
        begin
            word_taken <= char_ch.valid && char_ch.ready;

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_RADIX:  sh_radix  = cfg_ch.data;
                    CFG_SIGNED: sh_signed = cfg_ch.data[0];
                    CFG_WIDTH:  sh_width  = cfg_ch.data[1:0];
                    default:    ;
                endcase
            end

            // first error wins: later characters are dropped until last
            if (char_ch.valid && char_ch.ready)
            begin
                if (!char_ch.no_char && pr_err == ST_OK)
                    absorb_char(char_ch.char_code);
                if (char_ch.last)
                    finish_string();
            end

            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    flag_error($sformatf("unexpected word value %h status %0d",
                                         res_ch.value, res_ch.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.value !== want.value)
                        flag_error($sformatf("value expected %h got %h",
                                             want.value, res_ch.value));
                    if (res_ch.status !== want.status)
                        flag_error($sformatf("status expected %0d got %0d",
                                             want.status, res_ch.status));
                end
            end

            if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    // Watchdog: a long run of cycles with no word anywhere means a hang
    initial
    begin
        wait (rst_n === 1'b1);
        while (stuck_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int unsigned goal;
        int unsigned pick;
        int unsigned pos;
        int unsigned mode;

        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.no_char   = 1'b0;
        char_ch.last      = 1'b0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        cur_radix         = 5'd0;
        cur_signed        = 1'b1;
        cur_width         = 2'd3;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings at reset settings (auto radix, signed, 64 bit)
        send_text("");       // empty string, auto radix: invalid
        send_text("+");      // sign with no digits
        send_text("-");
        send_text("0");
        send_text("0x");     // bare prefixes give zero
        send_text("0b");
        send_text("+0xFf");
        send_text("-9");
        send_text("1a");     // hex digit in decimal
        send_text("+-");     // second sign
        send_text("a");      // auto mode must open with a decimal digit
        send_text("09");     // 9 is not octal
        wait_drained();

        // Minus taken while signed, then signed mode dropped before the end: invalid
        push_word(CH_MINUS, 1'b0, 1'b0);
        push_word(8'h35, 1'b0, 1'b0);
        wait_drained();
        write_config(5'd0, 1'b0, 2'd3);
        push_word(8'h00, 1'b1, 1'b1);
        wait_drained();

        // Random phases: every setting change happens with the parser idle
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_config(5'(RADIX_PLAN[p]), 1'((p / 4 + p / 2) % 2), 2'(p % 4));
            mode = (p + p / 4) % 4;
            case (mode)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 85;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 85;
                end
                default:
                begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 12;
                end
            endcase
            // fill the parser against a stalled result side once
            if (p == 0)
                -> start_long_hold;

            goal = items_queued + ITEMS_PER_PHASE;
            while (items_queued < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    build_number();
                else if (pick < 85)
                begin
                    // noise: arbitrary bytes and near-miss characters
                    line_buf.delete();
                    repeat ($urandom_range(0, 6))
                        line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                            : noise_pool[$urandom_range(0, noise_pool.len() - 1)]);
                end
                else
                begin
                    // broken number: bad char, cut short, or stray sign
                    build_number();
                    pos = $urandom_range(0, line_buf.size() - 1);
                    case ($urandom_range(0, 2))
                        0: line_buf[pos] = noise_pool[$urandom_range(0, noise_pool.len() - 1)];
                        1:
                        begin
                            while (line_buf.size() > pos)
                                void'(line_buf.pop_back());
                        end
                        default:
                            line_buf.insert(pos, $urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                    endcase
                end
                queue_line($urandom_range(0, 99) < 8);
            end
            wait_drained();
        end

        if (fail_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/aip_pkg.sv
rtl/aip_ifs.sv
rtl/aip_front.sv
rtl/aip_queue.sv
rtl/aip_back.sv
rtl/ascii_integer_parser_core.sv
bench/tb.sv
